// File: hdl/websocket_frame_header_parser_core_assert.svh
// Assertion macros for the header parser modules; used by the decode stage.
// Depends on nothing; included by modules that carry assertions.
`ifndef WEBSOCKET_FRAME_HEADER_PARSER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_HEADER_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSFHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSFHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/wsfhp_pkg.sv
// Package for the WebSocket frame header parser: field constants, opcodes,
// the result struct and the opcode check. Depends on nothing.
package wsfhp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned LEN_W     = 64;
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned OPCODE_W  = 4;
    localparam int unsigned LCODE_W   = 7;

    localparam logic [LCODE_W-1:0] LEN_CODE_16 = 7'd126;
    localparam logic [LCODE_W-1:0] LEN_CODE_64 = 7'd127;

    localparam logic [IDX_W-1:0] BASE_HDR_BYTES = 4'd2;
    localparam logic [IDX_W-1:0] EXT16_BYTES    = 4'd2;
    localparam logic [IDX_W-1:0] EXT64_BYTES    = 4'd8;
    localparam logic [IDX_W-1:0] KEY_BYTES      = 4'd4;

    localparam logic [IDX_W-1:0] IDX_FIRST  = 4'd0;
    localparam logic [IDX_W-1:0] IDX_SECOND = 4'd1;
    localparam logic [IDX_W-1:0] IDX_EXT    = 4'd2;
    localparam logic [IDX_W-1:0] IDX_LAST   = 4'd13;

    localparam logic [OPCODE_W-1:0] OP_CONT  = 4'h0;
    localparam logic [OPCODE_W-1:0] OP_TEXT  = 4'h1;
    localparam logic [OPCODE_W-1:0] OP_BIN   = 4'h2;
    localparam logic [OPCODE_W-1:0] OP_CLOSE = 4'h8;
    localparam logic [OPCODE_W-1:0] OP_PING  = 4'h9;
    localparam logic [OPCODE_W-1:0] OP_PONG  = 4'hA;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_MALFORMED = 1'b1;

    typedef struct packed {
        logic                status;
        logic                fin;
        logic [OPCODE_W-1:0] opcode;
        logic                masked;
        logic [LEN_W-1:0]    frame_len;
        logic [KEY_W-1:0]    masking_key;
        logic [IDX_W-1:0]    header_len;
    } t_hdr_result;

    function automatic logic opcode_known(input logic [OPCODE_W-1:0] op);
        logic known;
        case (op) inside
            OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG: known = 1'b1;
            default: known = 1'b0;
        endcase
        return known;
    endfunction

endpackage

// File: hdl/wsfhp_in_reg.sv
// Input register of the header parser: holds one received byte.
// Depends on wsfhp_pkg.
module wsfhp_in_reg
    import wsfhp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte,
    input  logic              i_ready
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // The register reloads whenever it is empty or its byte is taken.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// File: hdl/wsfhp_decode.sv
// Header decode stage: byte counter, first two bytes and the length and key
// accumulators. Depends on wsfhp_pkg and the assertion macro header.
`include "websocket_frame_header_parser_core_assert.svh"
module wsfhp_decode
    import wsfhp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_hdr_result       o_res,
    input  logic              i_res_ready
);

    logic [IDX_W-1:0]   r_idx;
    logic [BYTE_W-1:0]  r_first;
    logic [LCODE_W-1:0] r_lcode;
    logic               r_mask;
    logic [LEN_W-1:0]   r_len;
    logic [KEY_W-1:0]   r_key;

    logic [IDX_W-1:0]   n_idx;
    logic [BYTE_W-1:0]  n_first;
    logic [LCODE_W-1:0] n_lcode;
    logic               n_mask;
    logic [LEN_W-1:0]   n_len;
    logic [KEY_W-1:0]   n_key;

    logic               fire;
    logic               emit;
    logic [IDX_W-1:0]   ext_bytes;
    logic [IDX_W-1:0]   total_len;
    logic [IDX_W-1:0]   idx_inc;

    // A byte is consumed only when the result register can take a result.
    assign o_ready = i_res_ready;
    assign fire    = i_valid && i_res_ready;
    assign idx_inc = r_idx + 4'd1;

    always_comb begin
        n_idx     = r_idx;
        n_first   = r_first;
        n_lcode   = r_lcode;
        n_mask    = r_mask;
        n_len     = r_len;
        n_key     = r_key;
        emit      = 1'b0;
        ext_bytes = '0;
        total_len = '0;
        case (r_idx)
            IDX_FIRST: begin
                n_first = i_byte;
                n_lcode = '0;
                n_mask  = 1'b0;
                n_len   = '0;
                n_key   = '0;
                n_idx   = IDX_SECOND;
            end
            IDX_SECOND: begin
                n_lcode = i_byte[LCODE_W-1:0];
                n_mask  = i_byte[BYTE_W-1];
            end
            default: begin
            end
        endcase

        // Header length follows from the length code and mask flag in force.
        if (n_lcode == LEN_CODE_16) begin
            ext_bytes = EXT16_BYTES;
        end else if (n_lcode == LEN_CODE_64) begin
            ext_bytes = EXT64_BYTES;
        end
        total_len = BASE_HDR_BYTES + ext_bytes + (n_mask ? KEY_BYTES : '0);

        if (r_idx == IDX_SECOND) begin
            n_len = (ext_bytes == '0) ? {{(LEN_W-LCODE_W){1'b0}}, n_lcode} : '0;
            if (total_len == BASE_HDR_BYTES) begin
                emit  = 1'b1;
                n_idx = IDX_FIRST;
            end else begin
                n_idx = IDX_EXT;
            end
        end else if (r_idx != IDX_FIRST) begin
            if (r_idx < BASE_HDR_BYTES + ext_bytes) begin
                n_len = {r_len[LEN_W-BYTE_W-1:0], i_byte};
            end else begin
                n_key = {r_key[KEY_W-BYTE_W-1:0], i_byte};
            end
            if (idx_inc >= total_len) begin
                emit  = 1'b1;
                n_idx = IDX_FIRST;
            end else begin
                n_idx = idx_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= IDX_FIRST;
            r_first <= '0;
            r_lcode <= '0;
            r_mask  <= 1'b0;
            r_len   <= '0;
            r_key   <= '0;
        end else if (fire) begin
            r_idx   <= n_idx;
            r_first <= n_first;
            r_lcode <= n_lcode;
            r_mask  <= n_mask;
            r_len   <= n_len;
            r_key   <= n_key;
        end
    end

    assign o_res_valid        = fire && emit;
    assign o_res.status       = ((n_first[6:4] != 3'b000) || !opcode_known(n_first[3:0]))
                                ? STATUS_MALFORMED : STATUS_OK;
    assign o_res.fin          = n_first[BYTE_W-1];
    assign o_res.opcode       = n_first[OPCODE_W-1:0];
    assign o_res.masked       = n_mask;
    assign o_res.frame_len    = n_len;
    assign o_res.masking_key  = n_mask ? n_key : '0;
    assign o_res.header_len   = total_len;

    `WSFHP_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, 1'b1, r_idx <= IDX_LAST,
        "byte counter past the longest header")
    `WSFHP_ASSERT_IMP(a_len_matches_count, i_clk, i_rst_n, o_res_valid,
        o_res.header_len == idx_inc, "header length differs from bytes consumed")
    `WSFHP_ASSERT_NXT(a_restart_after_emit, i_clk, i_rst_n, o_res_valid,
        r_idx == IDX_FIRST, "counter did not restart after a complete header")
    `WSFHP_ASSERT_IMP(a_key_zero_unmasked, i_clk, i_rst_n, o_res_valid && !o_res.masked,
        o_res.masking_key == '0, "key nonzero on an unmasked header")

endmodule

// File: hdl/wsfhp_out_reg.sv
// Result register of the header parser: holds one decoded header result.
// Depends on wsfhp_pkg.
module wsfhp_out_reg
    import wsfhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_hdr_result i_res,
    output logic        o_valid,
    output t_hdr_result o_res,
    input  logic        i_ready
);

    logic        r_valid;
    t_hdr_result r_res;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: hdl/websocket_frame_header_parser_core.sv
// The last header byte is held in the input register, then decoded, and the header result is
// registered in the result register, from which the receiver takes it.
// Throughput: one header byte per cycle while no result waits; while a result waits, at most one
// more byte enters the input register and o_ready then stays low until the result leaves.
// Reset (i_rst_n low, synchronous) empties both registers and points the parser at byte 0.
// A header is 2, 4 or 10 bytes plus 4 key bytes when masked; depends on wsfhp_pkg.
module websocket_frame_header_parser_core
    import wsfhp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Byte channel, one header byte per item, in wire order.
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [BYTE_W-1:0]   i_data_byte,
    // Result channel, one item per complete header.
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_status,
    output logic                o_fin,
    output logic [OPCODE_W-1:0] o_opcode,
    output logic                o_masked,
    output logic [LEN_W-1:0]    o_frame_len,
    output logic [KEY_W-1:0]    o_masking_key,
    output logic [IDX_W-1:0]    o_header_len
);

    // Byte held in the input register and its handshake toward the decoder.
    logic              byte_valid;
    logic              byte_ready;
    logic [BYTE_W-1:0] byte_data;

    // Decoded result and its handshake toward the output register.
    logic              dec_valid;
    logic              dec_ready;
    t_hdr_result       dec_res;
    t_hdr_result       out_res;

    // The input register holds one byte for the decoder; its ready is high when it is
    // empty or when the decoder takes its byte in the same cycle.
    wsfhp_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .o_valid     (byte_valid),
        .o_byte      (byte_data),
        .i_ready     (byte_ready)
    );

    // The decoder consumes one byte per cycle whenever the result register has
    // room; bytes that do not finish a header produce no result item.
    wsfhp_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (byte_valid),
        .o_ready     (byte_ready),
        .i_byte      (byte_data),
        .o_res_valid (dec_valid),
        .o_res       (dec_res),
        .i_res_ready (dec_ready)
    );

    // The result register holds a finished header until the receiver takes it; no
    // byte is decoded while it is full and the receiver is not ready.
    wsfhp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_res   (dec_res),
        .o_valid (o_valid),
        .o_res   (out_res),
        .i_ready (i_ready)
    );

    assign o_status      = out_res.status;
    assign o_fin         = out_res.fin;
    assign o_opcode      = out_res.opcode;
    assign o_masked      = out_res.masked;
    assign o_frame_len   = out_res.frame_len;
    assign o_masking_key = out_res.masking_key;
    assign o_header_len  = out_res.header_len;

endmodule
